// ===== src/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and types for the linear interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

  // default datapath widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // output frames per input frame, at most
  localparam int MAX_OUT  = 16;
  localparam int CNT_BITS = $clog2(MAX_OUT);

  // configuration register indexes
  localparam int CFG_ADDR_BITS = 1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MODE = 1'b1;

  // channel arrangement
  typedef enum logic [1:0] {
    MODE_MONO    = 2'd0,
    MODE_STEREO  = 2'd1,
    MODE_ST2MONO = 2'd2,
    MODE_MONO2ST = 2'd3
  } mode_t;

endpackage

`default_nettype wire

// ===== src/linear_interp_resampler_core.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_core
// Linear interpolation sample rate converter with a streaming interface.
// ----------------------------------------------------------------------------
// Each input frame transfer yields zero or more output frames, interpolated
// between the previous and current input frames at a Q4.FRAC_BITS phase that
// advances by the step register per output; tlast marks the final output of
// an input. An input frame that gives no output passes through IDLE and
// FINISH only; one that gives n frames (up to the cap of 16) steps through
// MUL_L, MUL_R and EMIT for each, waiting in EMIT while the output side
// stalls, then FINISH. The single shared multiplier is used once per
// channel for each output frame, and EMIT loads the output register.
// in_tready is high only while the sequencer is idle; a finished frame
// waiting in the output register does not hold off the next input transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_core #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // configuration
  input  wire logic                                   cfg_we,
  input  wire logic [lir_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  wire logic [FRAC_BITS+3:0]                   cfg_wdata,
  // input frames; tdata: in_left, in_right
  input  wire logic                                   in_tvalid,
  output      logic                                   in_tready,
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // output frames; tdata: out_left, out_right
  output      logic                                   out_tvalid,
  input  wire logic                                   out_tready,
  output      logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,
  output      logic                                   out_tlast
);

  import lir_pkg::*;

  localparam int STEP_BITS = FRAC_BITS + 4;
  localparam int DATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
  localparam logic [STEP_BITS-1:0] PHASE_ONE = STEP_BITS'(1) << FRAC_BITS;
  localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(MAX_OUT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_EMIT,
    ST_FINISH
  } state_t;

  state_t                         state_r, state_nxt;
  logic [STEP_BITS-1:0]           step_r, step_nxt;
  mode_t                          mode_r, mode_nxt;
  logic [STEP_BITS-1:0]           phase_r, phase_nxt;
  logic signed [SAMPLE_BITS-1:0]  prev_left_r, prev_left_nxt;
  logic signed [SAMPLE_BITS-1:0]  prev_right_r, prev_right_nxt;
  logic signed [SAMPLE_BITS-1:0]  cur_left_r, cur_left_nxt;
  logic signed [SAMPLE_BITS-1:0]  cur_right_r, cur_right_nxt;
  logic signed [SAMPLE_BITS-1:0]  left_hold_r, left_hold_nxt;
  logic [CNT_BITS-1:0]            cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_left_r, out_left_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_right_r, out_right_nxt;
  logic                           out_last_r, out_last_nxt;

  // shared interpolator
  logic                           mul_start;
  logic signed [SAMPLE_BITS-1:0]  mul_a, mul_b, mul_res;

  // emit-cycle datapath
  logic                           stereo_in;
  logic [STEP_BITS:0]             phase_sum;
  logic [STEP_BITS-1:0]           phase_sat;
  logic                           frame_last;
  logic                           out_free;
  logic signed [SAMPLE_BITS:0]    mix_sum;
  logic signed [SAMPLE_BITS-1:0]  emit_left, emit_right;
  logic signed [SAMPLE_BITS-1:0]  in_left, in_right;

  assign in_left  = in_tdata[SAMPLE_BITS-1:0];
  assign in_right = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  assign stereo_in = (mode_r inside {MODE_STEREO, MODE_ST2MONO});

  assign mul_start = (state_r == ST_MUL_L) || (state_r == ST_MUL_R);
  assign mul_a     = (state_r == ST_MUL_R) ? prev_right_r : prev_left_r;
  assign mul_b     = (state_r == ST_MUL_R) ? cur_right_r  : cur_left_r;

  lir_interp_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp (
    .clk    (clk),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .frac   (phase_r[FRAC_BITS:0]),
    .result (mul_res)
  );

  // phase advance saturates at full scale
  assign phase_sum  = {1'b0, phase_r} + {1'b0, step_r};
  assign phase_sat  = phase_sum[STEP_BITS] ? '1 : phase_sum[STEP_BITS-1:0];
  assign frame_last = (phase_sat > PHASE_ONE) || (cnt_r == CNT_LAST);
  assign out_free   = !out_valid_r || out_tready;

  // in EMIT the unit holds the right channel, left was captured into left_hold in MUL_R
  assign mix_sum = $signed({left_hold_r[SAMPLE_BITS-1], left_hold_r})
                 + $signed({mul_res[SAMPLE_BITS-1], mul_res});

  always_comb begin
    emit_left  = left_hold_r;
    emit_right = left_hold_r;
    case (mode_r)
      MODE_STEREO:  emit_right = mul_res;
      MODE_ST2MONO: begin
        emit_left  = mix_sum[SAMPLE_BITS:1];
        emit_right = mix_sum[SAMPLE_BITS:1];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    cur_left_nxt   = cur_left_r;
    cur_right_nxt  = cur_right_r;
    left_hold_nxt  = left_hold_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      case (cfg_addr)
        REG_STEP: step_nxt = cfg_wdata;
        REG_MODE: mode_nxt = mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cur_left_nxt  = in_left;
          cur_right_nxt = stereo_in ? in_right : prev_right_r;
          cnt_nxt       = '0;
          state_nxt     = (phase_r <= PHASE_ONE) ? ST_MUL_L : ST_FINISH;
        end
      end
      ST_MUL_L: state_nxt = ST_MUL_R;
      ST_MUL_R: begin
        left_hold_nxt = mul_res;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = emit_left;
          out_right_nxt = emit_right;
          out_last_nxt  = frame_last;
          phase_nxt     = phase_sat;
          cnt_nxt       = cnt_r + CNT_BITS'(1);
          state_nxt     = frame_last ? ST_FINISH : ST_MUL_L;
        end
      end
      ST_FINISH: begin
        // phase at or below one here only after the cap: clamp to zero
        phase_nxt     = (phase_r > PHASE_ONE) ? (phase_r - PHASE_ONE) : '0;
        prev_left_nxt = cur_left_r;
        if (stereo_in) begin
          prev_right_nxt = cur_right_r;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= PHASE_ONE;
      mode_r       <= MODE_MONO;
      phase_r      <= PHASE_ONE;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      mode_r       <= mode_nxt;
      phase_r      <= phase_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cur_left_r  <= cur_left_nxt;
    cur_right_r <= cur_right_nxt;
    left_hold_r <= left_hold_nxt;
    cnt_r       <= cnt_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_BITS'({out_right_r, out_left_r});
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== src/lir_interp_unit.sv =====
// ----------------------------------------------------------------------------
// lir_interp_unit
// Shared interpolator: a + floor((b - a) * frac / 2^FRAC_BITS), product and a registered on start.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_interp_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          start,
  input  wire logic signed [SAMPLE_BITS-1:0] a,
  input  wire logic signed [SAMPLE_BITS-1:0] b,
  input  wire logic        [FRAC_BITS:0]     frac,
  output      logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 3;

  logic signed [SAMPLE_BITS:0]     diff;
  logic signed [PROD_BITS-1:0]     prod_c;
  logic signed [PROD_BITS-1:0]     prod_r;
  logic signed [SAMPLE_BITS-1:0]   a_r;

  assign diff   = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
  assign prod_c = diff * $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_c;
      a_r    <= a;
    end
  end

  // floor shift; low bits suffice since the result lies between a and b
  assign result = a_r + $signed(prod_r[FRAC_BITS +: SAMPLE_BITS]);

endmodule

`default_nettype wire
